>>> rtl/core/cdq_pkg.sv
// Package for the circular deque: codes, field widths and transaction types.
package cdq_pkg;

   localparam int DEPTH_DEF = 8;

   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 4;

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic signed [VALUE_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] popped_value;
      logic [OCC_W-1:0]          occupancy;
   } rsp_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                pop_ok;
      logic [OCC_W-1:0]    occupancy;
   } meta_type;

endpackage

>>> rtl/core/cdq_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/cdq_engine.sv
// Deque engine: head/tail/count registers, slot RAM access and status decode.
module cdq_engine #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  cdq_pkg::req_type                req,
   output cdq_pkg::meta_type               meta,
   output logic [cdq_pkg::VALUE_W-1:0]     rdata
);
   import cdq_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] i);
      wrap_inc = (i == LAST) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] i);
      wrap_dec = (i == '0) ? LAST : i - 1'b1;
   endfunction

   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   meta_type      meta_ff, meta_in;

   logic               we, re;
   logic [PW-1:0]      waddr, raddr;
   logic               is_push, is_front, full, empty;

   always_comb begin
      is_push  = (req.action == ACT_PUSH_FRONT) || (req.action == ACT_PUSH_BACK);
      is_front = (req.action == ACT_PUSH_FRONT) || (req.action == ACT_POP_FRONT);
      full     = (count_ff == FULL_CNT);
      empty    = (count_ff == '0);
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      we       = 1'b0;
      re       = 1'b0;
      waddr    = '0;
      raddr    = is_front ? head_ff : tail_ff;
      meta_in.status = STAT_OK;
      meta_in.pop_ok = 1'b0;
      if (is_push) begin
         if (full) begin
            meta_in.status = STAT_FULL;
         end else begin
            we = 1'b1;
            if (empty) begin
               head_in = '0;
               tail_in = '0;
               waddr   = '0;
            end else if (is_front) begin
               head_in = wrap_dec(head_ff);
               waddr   = head_in;
            end else begin
               tail_in = wrap_inc(tail_ff);
               waddr   = tail_in;
            end
            count_in = count_ff + 1'b1;
         end
      end else begin
         if (empty) begin
            meta_in.status = STAT_EMPTY;
         end else begin
            re             = 1'b1;
            meta_in.pop_ok = 1'b1;
            if (is_front) begin
               head_in = wrap_inc(head_ff);
            end else begin
               tail_in = wrap_dec(tail_ff);
            end
            count_in = count_ff - 1'b1;
            if (count_in == '0) begin
               head_in = '0;
               tail_in = '0;
            end
         end
      end
      meta_in.occupancy = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (start) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         meta_ff <= meta_in;
      end
   end

   cdq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock (clock),
      .we    (start & we),
      .waddr (waddr),
      .wdata (req.push_value),
      .re    (start & re),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign meta = meta_ff;

endmodule

>>> rtl/core/circular_deque.sv
// Circular deque top level: request sequencing and registered response.
// Response path: an accepted request moves IDLE to DATA, and DATA loads the
// registered response once the output is free. Requests are taken only in IDLE,
// so a new request waits until the previous response has been loaded.
// Reset clears head, tail, count and the response valid; slot RAM contents
// are not cleared and are only read after being written.
module circular_deque #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cdq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cdq_pkg::rsp_type rsp_payload
);
   import cdq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DATA = 1'b1;

   logic              state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              start, out_free;
   meta_type          meta;
   logic [VALUE_W-1:0] rdata;

   assign req_ready = (state_ff == ST_IDLE);
   assign start     = req_valid & req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   cdq_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req   (req_payload),
      .meta  (meta),
      .rdata (rdata)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               rsp_in.status       = meta.status;
               rsp_in.popped_value = meta.pop_ok ? rdata : '0;
               rsp_in.occupancy    = meta.occupancy;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
